// File: src/assert_macros.svh
// assertion macros shared by the rtl files
// no dependencies; assertions compile out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// File: src/bcdas_pkg.sv
// types and constants for the signed bcd add/subtract/shift unit
// no dependencies
package bcdas_pkg;

    localparam int MAX_DIGITS = 16;
    localparam int DIGITS_DEF = 16;
    localparam int FIELD_W    = 64;
    localparam int LEN_W      = 5;
    localparam int CMD_W      = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_DIV = 3'd3,
        CMD_CPL = 3'd4
    } t_cmd;

    // how the fixup stage treats the adder result
    typedef enum logic [1:0] {
        MODE_PASS = 2'd0,
        MODE_ADD  = 2'd1,
        MODE_SUB  = 2'd2
    } t_mode;

endpackage

// File: src/bcd_signed_add_sub_shift.sv
// Pipeline: five registered stages from input transfer to o_valid (operand prep, low-half
// digit add, high-half digit add, sign/recomplement fixup, length/output).
// Throughput: one item per cycle while not stalled; each pipeline stage frees as soon as the
// stage after it moves, so a waiting result blocks input only once all five stages hold items.
// Reset (i_rst_n low, synchronous) clears all stage valid bits only.
// Depends on bcdas_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bcd_signed_add_sub_shift #(
    parameter int DIGITS = bcdas_pkg::DIGITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [bcdas_pkg::CMD_W-1:0]     i_cmd,
    input  logic                            i_a_negative,
    input  logic [bcdas_pkg::FIELD_W-1:0]   i_a_digits,
    input  logic                            i_b_negative,
    input  logic [bcdas_pkg::FIELD_W-1:0]   i_b_digits,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_result_negative,
    output logic [bcdas_pkg::FIELD_W-1:0]   o_result_digits,
    output logic [bcdas_pkg::LEN_W-1:0]     o_result_length,
    output logic                            o_overflow
);

    localparam int W    = 4 * DIGITS;
    localparam int LO   = DIGITS / 2;
    localparam int HI   = DIGITS - LO;
    localparam int LO_W = 4 * LO;
    localparam int HI_W = W - LO_W;

    // one decimal digit add: {carry, digit}
    function automatic logic [4:0] dec_add(input logic [3:0] x, input logic [3:0] y,
                                           input logic c);
        logic [4:0] s;
        s = {1'b0, x} + {1'b0, y} + {4'b0, c};
        if (s > 5'd9) begin
            s = {1'b1, 4'(s - 5'd10)};
        end
        return s;
    endfunction

    function automatic logic [W-1:0] nines(input logic [W-1:0] v);
        logic [W-1:0] r;
        for (int i = 0; i < DIGITS; i++) begin
            r[4*i +: 4] = 4'd9 - v[4*i +: 4];
        end
        return r;
    endfunction

    // stage enables, back to front
    logic en_a, en_b, en_c, en_d, en_o;

    logic                 r_a_vld, r_b_vld, r_c_vld, r_d_vld, r_o_vld;

    // stage a: operand prep
    logic [W-1:0]         r_a_x, r_a_y, n_a_x, n_a_y;
    logic                 r_a_cin, n_a_cin;
    bcdas_pkg::t_mode     r_a_mode, n_a_mode;
    logic                 r_a_neg, n_a_neg;
    logic                 r_a_neg_alt, n_a_neg_alt;
    logic                 r_a_ovf, n_a_ovf;

    // stage b: low half summed
    logic [LO_W-1:0]      r_b_lo, n_b_lo;
    logic                 r_b_c, n_b_c;
    logic [HI_W-1:0]      r_b_xhi, r_b_yhi;
    bcdas_pkg::t_mode     r_b_mode;
    logic                 r_b_neg, r_b_neg_alt, r_b_ovf;

    // stage c: full sum
    logic [W-1:0]         r_c_sum, n_c_sum;
    logic                 r_c_cout, n_c_cout;
    bcdas_pkg::t_mode     r_c_mode;
    logic                 r_c_neg, r_c_neg_alt, r_c_ovf;

    // stage d: signed magnitude
    logic [W-1:0]         r_d_dig, n_d_dig;
    logic                 r_d_neg, n_d_neg;
    logic                 r_d_ovf, n_d_ovf;

    // output stage
    logic [bcdas_pkg::FIELD_W-1:0] r_o_dig, n_o_dig;
    logic                          r_o_neg, n_o_neg;
    logic [bcdas_pkg::LEN_W-1:0]   r_o_len, n_o_len;
    logic                          r_o_ovf, n_o_ovf;

    assign en_o    = !r_o_vld || !i_stall;
    assign en_d    = !r_d_vld || en_o;
    assign en_c    = !r_c_vld || en_d;
    assign en_b    = !r_b_vld || en_c;
    assign en_a    = !r_a_vld || en_b;
    assign o_stall = !en_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (en_a) begin
                r_a_vld <= i_valid;
            end
            if (en_b) begin
                r_b_vld <= r_a_vld;
            end
            if (en_c) begin
                r_c_vld <= r_b_vld;
            end
            if (en_d) begin
                r_d_vld <= r_c_vld;
            end
            if (en_o) begin
                r_o_vld <= r_d_vld;
            end
        end
    end

    // ---------------- stage a ----------------
    always_comb begin
        logic [W-1:0] ca, cb;
        logic         a_nz;
        logic         sb;
        for (int i = 0; i < DIGITS; i++) begin
            ca[4*i +: 4] = (i_a_digits[4*i +: 4] > 4'd9) ? 4'd9 : i_a_digits[4*i +: 4];
            cb[4*i +: 4] = (i_b_digits[4*i +: 4] > 4'd9) ? 4'd9 : i_b_digits[4*i +: 4];
        end
        a_nz        = |ca;
        sb          = i_b_negative ^ (i_cmd == bcdas_pkg::CMD_SUB);
        n_a_x       = ca;
        n_a_y       = '0;
        n_a_cin     = 1'b0;
        n_a_mode    = bcdas_pkg::MODE_PASS;
        n_a_neg     = i_a_negative;
        n_a_neg_alt = sb;
        n_a_ovf     = 1'b0;
        case (bcdas_pkg::t_cmd'(i_cmd))
            bcdas_pkg::CMD_ADD, bcdas_pkg::CMD_SUB: begin
                if (i_a_negative == sb) begin
                    n_a_y    = cb;
                    n_a_mode = bcdas_pkg::MODE_ADD;
                end else begin
                    // a + ten's complement of b
                    n_a_y    = nines(cb);
                    n_a_cin  = 1'b1;
                    n_a_mode = bcdas_pkg::MODE_SUB;
                end
            end
            bcdas_pkg::CMD_MUL: begin
                n_a_x   = {ca[W-5:0], 4'd0};
                n_a_ovf = |ca[W-1 -: 4];
            end
            bcdas_pkg::CMD_DIV: begin
                n_a_x = {4'd0, ca[W-1:4]};
            end
            bcdas_pkg::CMD_CPL: begin
                if (i_a_negative && a_nz) begin
                    n_a_x   = nines(ca);
                    n_a_cin = 1'b1;
                    n_a_neg = 1'b1;
                end else begin
                    n_a_neg = 1'b0;
                end
            end
            default: begin
                n_a_x = ca;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_x       <= n_a_x;
            r_a_y       <= n_a_y;
            r_a_cin     <= n_a_cin;
            r_a_mode    <= n_a_mode;
            r_a_neg     <= n_a_neg;
            r_a_neg_alt <= n_a_neg_alt;
            r_a_ovf     <= n_a_ovf;
        end
    end

    // ---------------- stage b: low digits ----------------
    always_comb begin
        logic       c;
        logic [4:0] s;
        c = r_a_cin;
        for (int i = 0; i < LO; i++) begin
            s               = dec_add(r_a_x[4*i +: 4], r_a_y[4*i +: 4], c);
            n_b_lo[4*i +: 4] = s[3:0];
            c               = s[4];
        end
        n_b_c = c;
    end

    always_ff @(posedge i_clk) begin
        if (en_b) begin
            r_b_lo      <= n_b_lo;
            r_b_c       <= n_b_c;
            r_b_xhi     <= r_a_x[W-1:LO_W];
            r_b_yhi     <= r_a_y[W-1:LO_W];
            r_b_mode    <= r_a_mode;
            r_b_neg     <= r_a_neg;
            r_b_neg_alt <= r_a_neg_alt;
            r_b_ovf     <= r_a_ovf;
        end
    end

    // ---------------- stage c: high digits ----------------
    always_comb begin
        logic       c;
        logic [4:0] s;
        c                   = r_b_c;
        n_c_sum[LO_W-1:0]   = r_b_lo;
        for (int i = 0; i < HI; i++) begin
            s                           = dec_add(r_b_xhi[4*i +: 4], r_b_yhi[4*i +: 4], c);
            n_c_sum[LO_W + 4*i +: 4]    = s[3:0];
            c                           = s[4];
        end
        n_c_cout = c;
    end

    always_ff @(posedge i_clk) begin
        if (en_c) begin
            r_c_sum     <= n_c_sum;
            r_c_cout    <= n_c_cout;
            r_c_mode    <= r_b_mode;
            r_c_neg     <= r_b_neg;
            r_c_neg_alt <= r_b_neg_alt;
            r_c_ovf     <= r_b_ovf;
        end
    end

    // ---------------- stage d: sign and recomplement ----------------
    always_comb begin
        logic [W-1:0] recomp;
        logic         low_zero;
        logic [3:0]   n;
        // ten's complement of the sum: nines plus one, carry runs over zero digits
        low_zero = 1'b1;
        for (int i = 0; i < DIGITS; i++) begin
            n = 4'd9 - r_c_sum[4*i +: 4];
            if (low_zero) begin
                n = (n == 4'd9) ? 4'd0 : n + 4'd1;
            end
            recomp[4*i +: 4] = n;
            low_zero         = low_zero && (r_c_sum[4*i +: 4] == 4'd0);
        end
        n_d_dig = r_c_sum;
        n_d_neg = r_c_neg;
        n_d_ovf = r_c_ovf;
        case (r_c_mode)
            bcdas_pkg::MODE_ADD: begin
                n_d_ovf = r_c_cout;
            end
            bcdas_pkg::MODE_SUB: begin
                if (!r_c_cout) begin
                    n_d_dig = recomp;
                    n_d_neg = r_c_neg_alt;
                end
            end
            default: begin
                n_d_dig = r_c_sum;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en_d) begin
            r_d_dig <= n_d_dig;
            r_d_neg <= n_d_neg;
            r_d_ovf <= n_d_ovf;
        end
    end

    // ---------------- output stage ----------------
    always_comb begin
        n_o_dig = '0;
        if (!r_d_ovf) begin
            n_o_dig[W-1:0] = r_d_dig;
        end
        n_o_ovf = r_d_ovf;
        n_o_neg = r_d_neg && !r_d_ovf && (r_d_dig != '0);
        n_o_len = bcdas_pkg::LEN_W'(1);
        for (int i = 0; i < DIGITS; i++) begin
            if (n_o_dig[4*i +: 4] != 4'd0) begin
                n_o_len = bcdas_pkg::LEN_W'(i + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_o) begin
            r_o_dig <= n_o_dig;
            r_o_neg <= n_o_neg;
            r_o_len <= n_o_len;
            r_o_ovf <= n_o_ovf;
        end
    end

    assign o_valid           = r_o_vld;
    assign o_result_negative = r_o_neg;
    assign o_result_digits   = r_o_dig;
    assign o_result_length   = r_o_len;
    assign o_overflow        = r_o_ovf;

    `ASSERT_PROP(a_ovf_clears, i_clk, i_rst_n,
        (o_valid && o_overflow) |-> (o_result_digits == '0 && !o_result_negative
        && o_result_length == bcdas_pkg::LEN_W'(1)), "overflow result not cleared")
    `ASSERT_NEVER(a_neg_zero, i_clk, i_rst_n,
        o_valid && o_result_negative && o_result_digits == '0, "negative zero at output")
    `ASSERT_PROP(a_len_range, i_clk, i_rst_n,
        o_valid |-> (o_result_length != '0 && o_result_length <= bcdas_pkg::LEN_W'(DIGITS)),
        "result length out of range")
    `ASSERT_PROP(a_stall_full, i_clk, i_rst_n,
        o_stall |-> (r_a_vld && r_b_vld && r_c_vld && r_d_vld && r_o_vld),
        "input stalled with a free stage")
    `ASSERT_PROP(a_accept_lands, i_clk, i_rst_n,
        (i_valid && !o_stall) |=> r_a_vld, "accepted item lost at first stage")

endmodule
